/* hw/rtl/sbcd_pkg.sv */
// Shared constants, codes and digit helpers for the signed BCD add/subtract/compare block.
`default_nettype none

package sbcd_pkg;

  localparam int DIGITS = 16;
  localparam int W      = 4 * DIGITS;

  typedef logic [W-1:0] mag_t;
  typedef logic [W:0]   sum_t;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_CMP = 2'd2,
    ACT_CMP_ALT = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  // Every digit is six: added ahead of the binary sum so that decimal carries
  // show up as binary nibble carries.
  function automatic mag_t sixes();
    mag_t r;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'd6;
    end
    return r;
  endfunction

  function automatic logic bcd_valid(input mag_t v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Nine's complement of a valid magnitude, digit by digit.
  function automatic mag_t nines(input mag_t v);
    mag_t r;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'd9 - v[4*i +: 4];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sbcd_if.sv */
// Handshake channels for operand and result transactions.
`default_nettype none

interface sbcd_in_if
  import sbcd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  mag_t       a_digits;
  logic       a_negative;
  mag_t       b_digits;
  logic       b_negative;

  modport source (output valid, action, a_digits, a_negative, b_digits, b_negative,
                  input ready);
  modport sink   (input valid, action, a_digits, a_negative, b_digits, b_negative,
                  output ready);
endinterface

interface sbcd_out_if
  import sbcd_pkg::*;
();
  logic              valid;
  logic              ready;
  mag_t              result_digits;
  logic              result_negative;
  logic signed [1:0] order;
  logic [1:0]        status;

  modport source (output valid, result_digits, result_negative, order, status,
                  input ready);
  modport sink   (input valid, result_digits, result_negative, order, status,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/sbcd_add_core.sv */
// Two-stage binary adder core for decimal sums: pre-bias by sixes, then add.
`default_nettype none

module sbcd_add_core
  import sbcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic en_bias,
  input  wire logic en_sum,
  input  wire mag_t p,
  input  wire mag_t q,
  input  wire logic cin,
  output mag_t      carries,
  output sum_t      sum
);

  mag_t biased;
  mag_t q_hold;
  logic cin_hold;
  sum_t sum_next;

  always_ff @(posedge clk) begin
    if (en_bias) begin
      biased   <= p + sixes();
      q_hold   <= q;
      cin_hold <= cin;
    end
  end

  assign sum_next = {1'b0, biased} + {1'b0, q_hold} + {{W{1'b0}}, cin_hold};

  // Bit 4k of the carry vector is the carry into nibble k.
  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum     <= sum_next;
      carries <= biased ^ q_hold ^ sum_next[W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/signed_bcd_add_sub_compare.sv */
// Top level: pipelined signed-magnitude BCD adder, subtractor and comparator.
//
//   channel   | dir | fields
//   ----------+-----+-----------------------------------------------------------
//   operands  | in  | action, a_digits, a_negative, b_digits, b_negative
//   results   | out | result_digits, result_negative, order, status
//
// Five register stages: input checks, magnitude compare and operand select,
// bias by sixes, binary add, decimal correction into the output register.
// One transaction is accepted per cycle while results is not stalled.
// Reset clears the stage valid bits only.
// A stall on results holds the full stages next to the output; stages before the first empty one keep filling.
`default_nettype none

module signed_bcd_add_sub_compare
  import sbcd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sbcd_in_if.sink   operands,
  sbcd_out_if.source results
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || results.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign operands.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= operands.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: validity, zero detect, sign cleanup.
  mag_t    s1_am, s1_bm;
  logic    s1_an, s1_bn, s1_bad, s1_bzero;
  action_t s1_act;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_am    <= operands.a_digits;
      s1_bm    <= operands.b_digits;
      s1_an    <= operands.a_negative && (operands.a_digits != '0);
      s1_bn    <= operands.b_negative && (operands.b_digits != '0);
      s1_bzero <= (operands.b_digits == '0);
      s1_bad   <= !bcd_valid(operands.a_digits) || !bcd_valid(operands.b_digits);
      s1_act   <= action_t'(operands.action);
    end
  end

  // Stage 2: magnitude compare, choose add or subtract and the operands.
  logic              cmp_op, a_ge, a_eq, ebn, do_sub;
  mag_t              p_next, q_next;
  logic              cin_next, sign_next;
  logic signed [1:0] ord_next;

  always_comb begin
    unique case (s1_act)
      ACT_ADD: cmp_op = 1'b0;
      ACT_SUB: cmp_op = 1'b0;
      ACT_CMP, ACT_CMP_ALT: cmp_op = 1'b1;
      default: cmp_op = 1'b1;
    endcase
    a_eq   = (s1_am == s1_bm);
    a_ge   = (s1_am >= s1_bm);
    ebn    = ((s1_act == ACT_SUB) ? !s1_bn : s1_bn) && !s1_bzero;
    do_sub = (s1_an != ebn);

    ord_next = ORD_EQUAL;
    if (!s1_bad && cmp_op) begin
      if (s1_an != s1_bn) begin
        ord_next = s1_an ? ORD_LESS : ORD_GREATER;
      end else if (!a_eq) begin
        ord_next = (a_ge != s1_an) ? ORD_GREATER : ORD_LESS;
      end
    end

    if (!do_sub) begin
      p_next    = s1_am;
      q_next    = s1_bm;
      cin_next  = 1'b0;
      sign_next = s1_an;
    end else if (a_ge) begin
      p_next    = s1_am;
      q_next    = nines(s1_bm);
      cin_next  = 1'b1;
      sign_next = s1_an;
    end else begin
      p_next    = s1_bm;
      q_next    = nines(s1_am);
      cin_next  = 1'b1;
      sign_next = ebn;
    end
  end

  mag_t              s2_p, s2_q;
  logic              s2_cin, s2_sign, s2_add, s2_zero, s2_bad;
  logic signed [1:0] s2_ord;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_p    <= p_next;
      s2_q    <= q_next;
      s2_cin  <= cin_next;
      s2_sign <= sign_next;
      s2_add  <= !do_sub && !cmp_op && !s1_bad;
      s2_zero <= cmp_op || s1_bad;
      s2_bad  <= s1_bad;
      s2_ord  <= ord_next;
    end
  end

  // Stages 3 and 4: biased binary add.
  mag_t carries;
  sum_t sum;

  sbcd_add_core u_core (
    .clk     (clk),
    .en_bias (en3),
    .en_sum  (en4),
    .p       (s2_p),
    .q       (s2_q),
    .cin     (s2_cin),
    .carries (carries),
    .sum     (sum)
  );

  logic              s3_sign, s3_add, s3_zero, s3_bad;
  logic signed [1:0] s3_ord;
  logic              s4_sign, s4_add, s4_zero, s4_bad;
  logic signed [1:0] s4_ord;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sign <= s2_sign;
      s3_add  <= s2_add;
      s3_zero <= s2_zero;
      s3_bad  <= s2_bad;
      s3_ord  <= s2_ord;
    end
    if (en4) begin
      s4_sign <= s3_sign;
      s4_add  <= s3_add;
      s4_zero <= s3_zero;
      s4_bad  <= s3_bad;
      s4_ord  <= s3_ord;
    end
  end

  // Stage 5: remove the six bias from every nibble that produced no carry.
  // Bit 4k+4 of carry_vec is the carry out of nibble k.
  logic [W:0] carry_vec;
  mag_t       digits_next;
  logic       nib_carry;
  logic       neg_next;
  logic [1:0] status_next;

  assign carry_vec = {sum[W], carries};

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      nib_carry = carry_vec[4*i + 4];
      digits_next[4*i +: 4] = nib_carry ? sum[4*i +: 4] : (sum[4*i +: 4] - 4'd6);
    end
    if (s4_zero) begin
      digits_next = '0;
    end
    neg_next = s4_sign && !s4_zero && (digits_next != '0);
    if (s4_bad) begin
      status_next = ST_INVALID;
    end else if (s4_add && sum[W]) begin
      status_next = ST_OVERFLOW;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      results.result_digits   <= digits_next;
      results.result_negative <= neg_next;
      results.order           <= s4_ord;
      results.status          <= status_next;
    end
  end

  assign results.valid = v5;

endmodule

`default_nettype wire

/* tb/tb_signed_bcd_add_sub_compare.sv */
// Self-checking testbench for the signed BCD add/subtract/compare block.
`timescale 1ns / 1ps

module tb_signed_bcd_add_sub_compare;
  import sbcd_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int RANDOM_RUNS = 10;
  localparam int RUN_ITEMS   = 133;

  typedef struct packed {
    action_t    action;
    mag_t       a_digits;
    logic       a_negative;
    mag_t       b_digits;
    logic       b_negative;
  } operand_t;

  typedef struct packed {
    mag_t              result_digits;
    logic              result_negative;
    logic signed [1:0] order;
    logic [1:0]        status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic steady;
  int   failures;
  int   sent_count;
  int   received_count;
  int   stall_left;
  int   idle_cycles;

  outcome_t pending_outcomes[$];

  sbcd_in_if  operands();
  sbcd_out_if results();

  signed_bcd_add_sub_compare u_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .results  (results)
  );

  always #5 clk = ~clk;

  function automatic logic digits_ok(input mag_t v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic mag_t decimal_sum(input mag_t x, input mag_t y, output logic carry);
    mag_t r;
    int   s;
    int   c;
    r = '0;
    c = 0;
    for (int i = 0; i < DIGITS; i++) begin
      s = int'(x[4*i +: 4]) + int'(y[4*i +: 4]) + c;
      c = (s >= 10) ? 1 : 0;
      if (c != 0) begin
        s = s - 10;
      end
      r[4*i +: 4] = s[3:0];
    end
    carry = (c != 0);
    return r;
  endfunction

  // The caller guarantees x >= y, so no borrow leaves the top digit.
  function automatic mag_t decimal_difference(input mag_t x, input mag_t y);
    mag_t r;
    int   xd;
    int   yd;
    int   d;
    int   borrow;
    r = '0;
    borrow = 0;
    for (int i = 0; i < DIGITS; i++) begin
      xd = int'(x[4*i +: 4]);
      yd = int'(y[4*i +: 4]) + borrow;
      if (xd < yd) begin
        d = xd + 10 - yd;
        borrow = 1;
      end else begin
        d = xd - yd;
        borrow = 0;
      end
      r[4*i +: 4] = d[3:0];
    end
    return r;
  endfunction

  function automatic outcome_t bcd_outcome(input operand_t op);
    outcome_t o;
    logic     an;
    logic     bn;
    logic     ebn;
    logic     carry;
    o  = '0;
    // A zero magnitude counts as positive whatever its sign bit says.
    an = op.a_negative && (op.a_digits != '0);
    bn = op.b_negative && (op.b_digits != '0);
    if (!digits_ok(op.a_digits) || !digits_ok(op.b_digits)) begin
      o.status = ST_INVALID;
    end else if (op.action == ACT_CMP || op.action == ACT_CMP_ALT) begin
      if (an != bn) begin
        o.order = an ? ORD_LESS : ORD_GREATER;
      end else if (op.a_digits != op.b_digits) begin
        o.order = ((op.a_digits > op.b_digits) != an) ? ORD_GREATER : ORD_LESS;
      end
    end else begin
      ebn = (op.action == ACT_SUB) ? !bn : bn;
      if (op.b_digits == '0) begin
        ebn = 1'b0;
      end
      if (an == ebn) begin
        o.result_digits   = decimal_sum(op.a_digits, op.b_digits, carry);
        o.result_negative = an;
        if (carry) begin
          o.status = ST_OVERFLOW;
        end
      end else if (op.a_digits >= op.b_digits) begin
        o.result_digits   = decimal_difference(op.a_digits, op.b_digits);
        o.result_negative = an;
      end else begin
        o.result_digits   = decimal_difference(op.b_digits, op.a_digits);
        o.result_negative = ebn;
      end
      if (o.result_digits == '0) begin
        o.result_negative = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic operand_t operand_pair(input action_t act, input mag_t a, input logic an,
                                            input mag_t b, input logic bn);
    operand_t op;
    op.action     = act;
    op.a_digits   = a;
    op.a_negative = an;
    op.b_digits   = b;
    op.b_negative = bn;
    return op;
  endfunction

  function automatic mag_t random_magnitude();
    mag_t m;
    int   len;
    m = '0;
    case ($urandom_range(0, 9))
      0: begin
        m = '0;
      end
      1: begin
        m = {DIGITS{4'd9}};
      end
      2, 3, 4: begin
        for (int i = 0; i < DIGITS; i++) begin
          m[4*i +: 4] = 4'($urandom_range(0, 9));
        end
      end
      default: begin
        len = $urandom_range(1, DIGITS);
        for (int i = 0; i < len; i++) begin
          m[4*i +: 4] = 4'($urandom_range(0, 9));
        end
      end
    endcase
    return m;
  endfunction

  function automatic mag_t corrupt_digit(input mag_t m);
    int pos;
    pos = $urandom_range(0, DIGITS - 1);
    m[4*pos +: 4] = 4'($urandom_range(10, 15));
    return m;
  endfunction

  function automatic operand_t random_operands();
    operand_t op;
    int       pos;
    op.action     = action_t'($urandom_range(0, 3));
    op.a_digits   = random_magnitude();
    op.a_negative = 1'($urandom_range(0, 1));
    op.b_negative = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        op.b_digits = op.a_digits;
      end
      1: begin
        // Near miss: same magnitude but for one digit.
        pos = $urandom_range(0, DIGITS - 1);
        op.b_digits = op.a_digits;
        op.b_digits[4*pos +: 4] = 4'($urandom_range(0, 9));
      end
      default: begin
        op.b_digits = random_magnitude();
      end
    endcase
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: op.a_digits = corrupt_digit(op.a_digits);
        1: op.b_digits = corrupt_digit(op.b_digits);
        default: begin
          op.a_digits = corrupt_digit(op.a_digits);
          op.b_digits = corrupt_digit(op.b_digits);
        end
      endcase
    end
    return op;
  endfunction

  task automatic send_operands(input operand_t op);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      operands.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands.valid      <= 1'b1;
    operands.action     <= op.action;
    operands.a_digits   <= op.a_digits;
    operands.a_negative <= op.a_negative;
    operands.b_digits   <= op.b_digits;
    operands.b_negative <= op.b_negative;
    do @(posedge clk); while (!operands.ready);
    sent_count++;
  endtask

  task automatic await_all_results();
    operands.valid <= 1'b0;
    while (received_count != sent_count) @(posedge clk);
  endtask

  task automatic test_signed_zero();
    send_operands(operand_pair(ACT_ADD, '0, 1'b0, '0, 1'b0));
    send_operands(operand_pair(ACT_ADD, '0, 1'b1, '0, 1'b1));
    send_operands(operand_pair(ACT_SUB, '0, 1'b0, '0, 1'b1));
    send_operands(operand_pair(ACT_CMP, '0, 1'b1, '0, 1'b0));
    send_operands(operand_pair(ACT_SUB, 64'h12, 1'b1, 64'h12, 1'b1));
  endtask

  task automatic test_carry_wrap();
    mag_t nines;
    mag_t half;
    nines = {DIGITS{4'd9}};
    half  = mag_t'(4'd5) << (4 * (DIGITS - 1));
    send_operands(operand_pair(ACT_ADD, nines, 1'b0, 64'h1, 1'b0));
    send_operands(operand_pair(ACT_ADD, nines, 1'b1, nines, 1'b1));
    send_operands(operand_pair(ACT_SUB, nines, 1'b0, nines, 1'b1));
    // Both of these wrap to exactly zero, which must come out positive.
    send_operands(operand_pair(ACT_ADD, half, 1'b0, half, 1'b0));
    send_operands(operand_pair(ACT_SUB, half, 1'b1, half, 1'b0));
  endtask

  task automatic test_sign_rules();
    send_operands(operand_pair(ACT_SUB, 64'h5, 1'b0, 64'h7, 1'b0));
    send_operands(operand_pair(ACT_ADD, 64'h7, 1'b1, 64'h5, 1'b0));
    send_operands(operand_pair(ACT_ADD, 64'h12, 1'b0, 64'h12, 1'b1));
    send_operands(operand_pair(ACT_SUB, 64'h3, 1'b1, 64'h8, 1'b1));
    send_operands(operand_pair(ACT_ADD, {DIGITS{4'd9}}, 1'b0, 64'h1, 1'b1));
  endtask

  task automatic test_compare();
    send_operands(operand_pair(ACT_CMP, 64'h3, 1'b0, 64'h5, 1'b0));
    send_operands(operand_pair(ACT_CMP, 64'h3, 1'b1, 64'h5, 1'b1));
    send_operands(operand_pair(ACT_CMP, 64'h1, 1'b1, 64'h1, 1'b0));
    send_operands(operand_pair(ACT_CMP, {DIGITS{4'd9}}, 1'b1, {DIGITS{4'd9}}, 1'b1));
    send_operands(operand_pair(ACT_CMP_ALT, 64'h8, 1'b0, 64'h8, 1'b1));
    send_operands(operand_pair(ACT_CMP, 64'h1, 1'b0, '0, 1'b1));
  endtask

  task automatic test_invalid_digits();
    send_operands(operand_pair(ACT_ADD, '1, 1'b1, '1, 1'b1));
    send_operands(operand_pair(ACT_SUB, 64'h5, 1'b0, mag_t'(4'hA) << (4 * (DIGITS - 1)), 1'b0));
    send_operands(operand_pair(ACT_CMP, 64'h1B, 1'b1, 64'h2, 1'b0));
    send_operands(operand_pair(ACT_CMP_ALT, 64'h9, 1'b0, 64'hC0, 1'b1));
  endtask

  task automatic test_random();
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      // Every third run goes back to back on both sides.
      steady = (run % 3 == 2);
      if (run == RANDOM_RUNS / 2) begin
        await_all_results();
      end
      for (int n = 0; n < RUN_ITEMS; n++) begin
        send_operands(random_operands());
      end
    end
    steady = 1'b0;
  endtask

  // Result sink: after each transaction, holds ready low for a drawn number of cycles.
  always @(posedge clk) begin
    if (results.valid && results.ready) begin
      stall_left = steady ? 0 : $urandom_range(0, 6);
      if (stall_left > 0) begin
        results.ready <= 1'b0;
      end
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) begin
        results.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    operand_t op;
    if (!rst) begin
      if (results.valid && results.ready) begin
        received_count++;
        got.result_digits   = results.result_digits;
        got.result_negative = results.result_negative;
        got.order           = results.order;
        got.status          = results.status;
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with nothing outstanding");
          failures++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.result_digits !== want.result_digits) begin
            $error("result_digits: expected %h, got %h", want.result_digits,
                   got.result_digits);
            failures++;
          end
          if (got.result_negative !== want.result_negative) begin
            $error("result_negative: expected %b, got %b", want.result_negative,
                   got.result_negative);
            failures++;
          end
          if (got.order !== want.order) begin
            $error("order: expected %0d, got %0d", want.order, got.order);
            failures++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
          end
        end
      end
      if (operands.valid && operands.ready) begin
        op.action     = action_t'(operands.action);
        op.a_digits   = operands.a_digits;
        op.a_negative = operands.a_negative;
        op.b_digits   = operands.b_digits;
        op.b_negative = operands.b_negative;
        pending_outcomes.push_back(bcd_outcome(op));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (operands.valid && operands.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    steady              = 1'b0;
    failures            = 0;
    sent_count          = 0;
    received_count      = 0;
    stall_left          = 0;
    idle_cycles         = 0;
    operands.valid      = 1'b0;
    operands.action     = ACT_ADD;
    operands.a_digits   = '0;
    operands.a_negative = 1'b0;
    operands.b_digits   = '0;
    operands.b_negative = 1'b0;
    results.ready       = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_signed_zero();
    test_carry_wrap();
    test_sign_rules();
    test_compare();
    test_invalid_digits();
    await_all_results();
    test_random();

    await_all_results();
    // Five pipeline stages; leave room for anything unexpected to surface.
    repeat (10) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", pending_outcomes.size());
      failures++;
    end
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sbcd_pkg.sv
hw/rtl/sbcd_if.sv
hw/rtl/sbcd_add_core.sv
hw/rtl/signed_bcd_add_sub_compare.sv
tb/tb_signed_bcd_add_sub_compare.sv
